// File: rtl/rfde_pkg.sv
// Shared types and constants of the reference frame delta encoder.
`timescale 1ns / 1ps
`default_nettype none

package rfde_pkg;

    // Field widths fixed by the stream format.
    localparam int THR_W    = 10;
    localparam int WC_W     = 17;
    localparam int DIST_W   = 31;
    localparam int FILL_W   = 6;
    localparam int BODY_N_W = 7;
    localparam int Q8_FRAC  = 8;

    localparam logic [THR_W-1:0]  THR_RESET = 10'd256;
    localparam logic [WC_W-1:0]   WC_MAX    = 17'h1FFFF;
    localparam logic [DIST_W-1:0] DIST_MAX  = 31'h7FFF_FFFF;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Bytes of the encoded stream.
    localparam logic [7:0] HDR_REF_BYTE   = 8'h00;
    localparam logic [7:0] HDR_DELTA_BYTE = 8'h01;
    localparam logic [7:0] COPY_BYTE      = 8'h43;
    localparam logic [7:0] PATCH_BYTE     = 8'h50;

    // Header that a command opens with.
    typedef enum logic [1:0] {
        HDR_NONE,
        HDR_REF,
        HDR_DELTA
    } t_hdr;

    // Body that a command carries after any header.
    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_PASS,
        BODY_COPY,
        BODY_PATCH
    } t_body;

    // Output sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HDR,
        BK_DIST,
        BK_BODY,
        BK_DATA
    } t_back_state;

    // One queued command: all results caused by one input byte.
    typedef struct packed {
        t_hdr              hdr;
        t_body             body;
        logic [7:0]        data;
        logic [DIST_W-1:0] distance;
        logic              bank;
        logic [FILL_W-1:0] count;
        logic              was_ref;
        logic              frame_end;
        logic              overflow;
        logic [WC_W-1:0]   size;
    } t_cmd;

    // Write into the two-bank block buffer.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [FILL_W-1:0] idx;
        logic [7:0]        data;
    } t_bb_wr;

    // The back has finished reading a block buffer bank.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_rel;

endpackage

`default_nettype wire

// File: rtl/rfde_in_if.sv
// Input byte channel of the reference frame delta encoder.
`timescale 1ns / 1ps
`default_nettype none

interface rfde_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_frame;

    modport source (output valid, data_byte, last_of_frame, input ready);
    modport sink (input valid, data_byte, last_of_frame, output ready);
endinterface

`default_nettype wire

// File: rtl/rfde_out_if.sv
// Encoded output channel of the reference frame delta encoder.
`timescale 1ns / 1ps
`default_nettype none

interface rfde_out_if;
    logic                      valid;
    logic                      ready;
    logic [7:0]                out_byte;
    logic                      last_of_run;
    logic                      frame_end;
    logic                      frame_was_reference;
    logic [rfde_pkg::WC_W-1:0] frame_written_size;
    logic                      frame_overflow;

    modport source (output valid, out_byte, last_of_run, frame_end, frame_was_reference,
                    frame_written_size, frame_overflow, input ready);
    modport sink (input valid, out_byte, last_of_run, frame_end, frame_was_reference,
                  frame_written_size, frame_overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/rfde_front.sv
// Front end: takes frame bytes, compares them with the reference and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module rfde_front #(
    parameter int BLOCK_BYTES = 32,
    parameter int REF_BYTES   = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rfde_in_if.sink                    i_in,
    input  logic                       i_cfg_we,
    input  logic [rfde_pkg::THR_W-1:0] i_cfg_wdata,
    input  logic                       i_q_ready,
    output logic                       o_q_push,
    output rfde_pkg::t_cmd             o_q_cmd,
    output rfde_pkg::t_bb_wr           o_bb_wr,
    input  rfde_pkg::t_bank_rel        i_rel
);
    import rfde_pkg::*;

    localparam int POS_W  = $clog2(REF_BYTES + 1);
    localparam int REF_AW = $clog2(REF_BYTES);
    localparam int LIM_W  = POS_W + THR_W;
    localparam int CMP_W  = (WC_W + Q8_FRAC > LIM_W) ? WC_W + Q8_FRAC : LIM_W;

    // Reference store and its registered read port.
    logic [7:0]        r_store [REF_BYTES];
    logic [7:0]        r_ref_rd;
    logic              st_we;
    logic [REF_AW-1:0] st_wa;
    logic [REF_AW-1:0] st_ra;

    // Frame and reference state.
    logic [THR_W-1:0]  r_thr;
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [FILL_W-1:0] r_fill,      n_fill;
    logic              r_differs,   n_differs;
    logic              r_delta,     n_delta;
    logic [WC_W-1:0]   r_wc,        n_wc;
    logic              r_ref_valid, n_ref_valid;
    logic [POS_W-1:0]  r_ref_len,   n_ref_len;
    logic [DIST_W-1:0] r_dist,      n_dist;
    logic              r_bank,      n_bank;
    logic [1:0]        r_bank_busy, n_bank_busy;

    logic              accept;
    logic              discard;
    logic              start;
    logic              ref_mode;
    logic              close;
    logic              byte_differs;
    logic              diff_acc;
    logic              flush;
    logic [POS_W-1:0]  pos_inc;
    logic [FILL_W-1:0] fill_cur;
    logic [FILL_W-1:0] fill_inc;
    logic [DIST_W-1:0] dist_new;
    logic [2:0]        hdr_n;
    logic [BODY_N_W-1:0] body_n;
    logic [WC_W-1:0]   wc_base;
    logic [WC_W:0]     wc_sum;
    logic [WC_W-1:0]   wc_new;
    logic [LIM_W-1:0]  limit;
    logic              too_big;
    t_hdr              cmd_hdr;
    t_body             cmd_body;

    // A byte is taken when the queue has room and the bank to fill is free.
    assign i_in.ready = i_q_ready && !r_bank_busy[r_bank];
    assign accept     = i_in.valid && i_in.ready;

    // Classification of the byte on the input.
    assign discard  = (r_pos == POS_W'(REF_BYTES));
    assign start    = (r_pos == '0);
    assign ref_mode = start ? (!r_ref_valid || (r_dist == DIST_MAX)) : !r_delta;
    assign pos_inc  = r_pos + 1'b1;
    assign close    = i_in.last_of_frame || (pos_inc == POS_W'(REF_BYTES));
    assign fill_cur = start ? '0 : r_fill;
    assign fill_inc = fill_cur + 1'b1;
    assign dist_new = start ? (ref_mode ? '0 : r_dist + 1'b1) : r_dist;

    assign byte_differs = (r_pos >= r_ref_len) || (r_ref_rd != i_in.data_byte);
    assign diff_acc     = (!start && r_differs) || byte_differs;
    assign flush        = !ref_mode && ((fill_inc == FILL_W'(BLOCK_BYTES)) || close);

    // What this byte makes the back send.
    always_comb begin
        if (!start) begin
            cmd_hdr = HDR_NONE;
            hdr_n   = 3'd0;
        end else if (ref_mode) begin
            cmd_hdr = HDR_REF;
            hdr_n   = 3'd1;
        end else begin
            cmd_hdr = HDR_DELTA;
            hdr_n   = 3'd5;
        end

        if (ref_mode) begin
            cmd_body = BODY_PASS;
        end else if (!flush) begin
            cmd_body = BODY_NONE;
        end else if (diff_acc) begin
            cmd_body = BODY_PATCH;
        end else begin
            cmd_body = BODY_COPY;
        end

        unique case (cmd_body)
            BODY_NONE:  body_n = '0;
            BODY_PASS:  body_n = BODY_N_W'(1);
            BODY_COPY:  body_n = BODY_N_W'(1);
            BODY_PATCH: body_n = BODY_N_W'(fill_inc) + 1'b1;
        endcase
    end

    // Written size so far, saturating.
    assign wc_base = start ? '0 : r_wc;
    assign wc_sum  = (WC_W+1)'(wc_base) + (WC_W+1)'(hdr_n) + (WC_W+1)'(body_n);
    assign wc_new  = (wc_sum > (WC_W+1)'(WC_MAX)) ? WC_MAX : wc_sum[WC_W-1:0];

    // Discard test: written size * 256 against frame length * threshold.
    assign limit   = LIM_W'(pos_inc) * LIM_W'(r_thr);
    assign too_big = CMP_W'({wc_new, {Q8_FRAC{1'b0}}}) > CMP_W'(limit);

    // Command to the queue.
    always_comb begin
        o_q_cmd.hdr       = cmd_hdr;
        o_q_cmd.body      = cmd_body;
        o_q_cmd.data      = i_in.data_byte;
        o_q_cmd.distance  = dist_new;
        o_q_cmd.bank      = r_bank;
        o_q_cmd.count     = fill_inc;
        o_q_cmd.was_ref   = ref_mode;
        o_q_cmd.frame_end = close;
        o_q_cmd.overflow  = close && !i_in.last_of_frame;
        o_q_cmd.size      = wc_new;
    end

    assign o_q_push = accept && !discard && ((cmd_hdr != HDR_NONE) || (cmd_body != BODY_NONE));

    // Block buffer write for delta bytes.
    always_comb begin
        o_bb_wr.en   = accept && !discard && !ref_mode;
        o_bb_wr.bank = r_bank;
        o_bb_wr.idx  = fill_cur;
        o_bb_wr.data = i_in.data_byte;
    end

    // Next frame and reference state.
    always_comb begin
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_differs   = r_differs;
        n_delta     = r_delta;
        n_wc        = r_wc;
        n_ref_valid = r_ref_valid;
        n_ref_len   = r_ref_len;
        n_dist      = r_dist;
        n_bank      = r_bank;
        n_bank_busy = r_bank_busy;

        if (i_rel.valid) begin
            n_bank_busy[i_rel.bank] = 1'b0;
        end

        if (accept) begin
            if (discard) begin
                if (i_in.last_of_frame) begin
                    n_pos = '0;
                end
            end else begin
                n_delta   = !ref_mode;
                n_dist    = dist_new;
                n_wc      = wc_new;
                n_fill    = (ref_mode || flush) ? '0 : fill_inc;
                n_differs = !ref_mode && !flush && diff_acc;
                if (flush) begin
                    n_bank              = !r_bank;
                    n_bank_busy[r_bank] = 1'b1;
                end
                if (close) begin
                    n_pos = i_in.last_of_frame ? '0 : POS_W'(REF_BYTES);
                    if (ref_mode) begin
                        n_ref_valid = 1'b1;
                        n_ref_len   = pos_inc;
                    end else if (too_big) begin
                        n_ref_valid = 1'b0;
                    end
                end else begin
                    n_pos = pos_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_pos       <= '0;
            r_fill      <= '0;
            r_differs   <= 1'b0;
            r_delta     <= 1'b0;
            r_wc        <= '0;
            r_ref_valid <= 1'b0;
            r_ref_len   <= '0;
            r_dist      <= '0;
            r_bank      <= 1'b0;
            r_bank_busy <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_differs   <= n_differs;
            r_delta     <= n_delta;
            r_wc        <= n_wc;
            r_ref_valid <= n_ref_valid;
            r_ref_len   <= n_ref_len;
            r_dist      <= n_dist;
            r_bank      <= n_bank;
            r_bank_busy <= n_bank_busy;
        end
    end

    // The store is read ahead at the next position, with write-through on a clash.
    assign st_we = accept && !discard && ref_mode;
    assign st_wa = r_pos[REF_AW-1:0];
    assign st_ra = n_pos[REF_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_wa] <= i_in.data_byte;
        end
        if (st_we && (st_wa == st_ra)) begin
            r_ref_rd <= i_in.data_byte;
        end else begin
            r_ref_rd <= r_store[st_ra];
        end
    end

    // A partial block never reaches the block size between bytes.
    a_fill_below_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_W'(BLOCK_BYTES))
        else $error("block fill reached the block size");

    // The back only hands back a bank that the front marked busy.
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rel.valid |-> r_bank_busy[i_rel.bank])
        else $error("release of a bank that was not busy");

endmodule

`default_nettype wire

// File: rtl/rfde_queue.sv
// Short command queue between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rfde_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rfde_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output rfde_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import rfde_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Occupancy stays within the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue occupancy beyond its depth");

endmodule

`default_nettype wire

// File: rtl/rfde_back.sv
// Output sequencer: expands queued commands into encoded bytes, holds the block buffer.
`timescale 1ns / 1ps
`default_nettype none

module rfde_back #(
    parameter int BLOCK_BYTES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  rfde_pkg::t_cmd      i_q_cmd,
    output logic                o_q_pop,
    input  rfde_pkg::t_bb_wr    i_bb_wr,
    output rfde_pkg::t_bank_rel o_rel,
    rfde_out_if.source          o_out
);
    import rfde_pkg::*;

    localparam int BB_IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int BB_DEPTH = 2 * (1 << BB_IDX_W);

    // Two-bank block buffer, one bank per block in flight.
    logic [7:0]          r_bb [BB_DEPTH];
    logic [7:0]          r_bb_rd;
    logic [BB_IDX_W:0]   bb_wa;
    logic [BB_IDX_W:0]   bb_ra;

    t_back_state         r_state, n_state;
    t_cmd                r_cmd,   n_cmd;
    logic [FILL_W-1:0]   r_idx,   n_idx;

    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_last;
    logic                r_out_end;
    logic                r_out_ref;
    logic [WC_W-1:0]     r_out_size;
    logic                r_out_ovf;

    logic                load_ok;
    logic                emit;
    logic                emit_last;
    logic [7:0]          emit_byte;
    logic [7:0]          dist_byte;

    // The output register is free when empty or being taken.
    assign load_ok = !r_out_valid || o_out.ready;

    // Distance byte for the current position, little-endian.
    always_comb begin
        unique case (r_idx[1:0])
            2'd0: dist_byte = r_cmd.distance[7:0];
            2'd1: dist_byte = r_cmd.distance[15:8];
            2'd2: dist_byte = r_cmd.distance[23:16];
            2'd3: dist_byte = {1'b0, r_cmd.distance[30:24]};
        endcase
    end

    // Next state, the byte to send and the queue pop.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_byte = HDR_REF_BYTE;
        o_q_pop   = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                n_state = BK_IDLE;
            end
            BK_HDR: begin
                if (load_ok) begin
                    emit = 1'b1;
                    if (r_cmd.hdr == HDR_DELTA) begin
                        emit_byte = HDR_DELTA_BYTE;
                        n_state   = BK_DIST;
                        n_idx     = '0;
                    end else if (r_cmd.body != BODY_NONE) begin
                        n_state = BK_BODY;
                    end else begin
                        emit_last = 1'b1;
                    end
                end
            end
            BK_DIST: begin
                if (load_ok) begin
                    emit      = 1'b1;
                    emit_byte = dist_byte;
                    if (r_idx[1:0] != 2'd3) begin
                        n_idx = r_idx + 1'b1;
                    end else if (r_cmd.body != BODY_NONE) begin
                        n_state = BK_BODY;
                    end else begin
                        emit_last = 1'b1;
                    end
                end
            end
            BK_BODY: begin
                if (load_ok) begin
                    emit = 1'b1;
                    if (r_cmd.body == BODY_PATCH) begin
                        emit_byte = PATCH_BYTE;
                        n_state   = BK_DATA;
                        n_idx     = '0;
                    end else if (r_cmd.body == BODY_COPY) begin
                        emit_byte = COPY_BYTE;
                        emit_last = 1'b1;
                    end else begin
                        emit_byte = r_cmd.data;
                        emit_last = 1'b1;
                    end
                end
            end
            BK_DATA: begin
                if (load_ok) begin
                    emit      = 1'b1;
                    emit_byte = r_bb_rd;
                    if (r_idx == FILL_W'(r_cmd.count - 1'b1)) begin
                        emit_last = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        // Take the next command as soon as the current one is done.
        if ((r_state == BK_IDLE) || emit_last) begin
            if (i_q_valid) begin
                o_q_pop = 1'b1;
                n_cmd   = i_q_cmd;
                n_state = (i_q_cmd.hdr != HDR_NONE) ? BK_HDR : BK_BODY;
            end else begin
                n_state = BK_IDLE;
            end
        end
    end

    // A finished block command frees its bank.
    always_comb begin
        o_rel.valid = emit_last && ((r_cmd.body == BODY_COPY) || (r_cmd.body == BODY_PATCH));
        o_rel.bank  = r_cmd.bank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_ok) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
            r_out_end  <= emit_last && r_cmd.frame_end;
            r_out_ref  <= r_cmd.was_ref;
            r_out_size <= (emit_last && r_cmd.frame_end) ? r_cmd.size : '0;
            r_out_ovf  <= emit_last && r_cmd.frame_end && r_cmd.overflow;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.out_byte            = r_out_byte;
    assign o_out.last_of_run         = r_out_last;
    assign o_out.frame_end           = r_out_end;
    assign o_out.frame_was_reference = r_out_ref;
    assign o_out.frame_written_size  = r_out_size;
    assign o_out.frame_overflow      = r_out_ovf;

    // Block buffer: the read runs one index ahead so that data waits in r_bb_rd.
    assign bb_wa = {i_bb_wr.bank, i_bb_wr.idx[BB_IDX_W-1:0]};
    assign bb_ra = {r_cmd.bank, n_idx[BB_IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_bb_wr.en) begin
            r_bb[bb_wa] <= i_bb_wr.data;
        end
        r_bb_rd <= r_bb[bb_ra];
    end

    // Block bytes are only sent for a differing block.
    a_data_only_patch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DATA) |-> (r_cmd.body == BODY_PATCH))
        else $error("block bytes sent for a command without a patch body");

    // Distance bytes only follow a delta header.
    a_dist_only_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIST) |-> (r_cmd.hdr == HDR_DELTA))
        else $error("distance bytes sent without a delta header");

endmodule

`default_nettype wire

// File: rtl/reference_frame_delta_encoder.sv
// Top level of the reference frame delta encoder.
//
// Channel  Direction  Payload                                          Transfer when
// i_in     in         data_byte[7:0], last_of_frame                    valid && ready
// o_out    out        out_byte[7:0], last_of_run, frame_end,           valid && ready
//                     frame_was_reference, frame_written_size[16:0],
//                     frame_overflow
// cfg      in         i_cfg_wdata[9:0] to threshold_q8                 i_cfg_we
//
// The front takes one byte per cycle unless the queue is full or its bank busy;
// the output sequencer, which sets the sustained rate, sends one byte per cycle
// while the output is taken. A reference frame of N bytes encodes to N+1 bytes,
// a delta one to 5 header bytes, 1 per matching and B+1 per differing B-byte block.
// Reset clears control state only; the reference store is not cleared and needs no
// pass, as only entries below the stored reference length are compared.
// A four-entry command queue and a two-bank block buffer let the input run up to
// one block ahead of a stalled output.
`timescale 1ns / 1ps
`default_nettype none

module reference_frame_delta_encoder #(
    parameter int BLOCK_BYTES = 32,
    parameter int REF_BYTES   = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rfde_in_if.sink                    i_in,
    rfde_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [rfde_pkg::THR_W-1:0] i_cfg_wdata
);
    import rfde_pkg::*;

    logic      q_push;
    logic      q_ready;
    logic      q_valid;
    logic      q_pop;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    t_bb_wr    bb_wr;
    t_bank_rel bank_rel;

    rfde_front #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .REF_BYTES   (REF_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_ready   (q_ready),
        .o_q_push    (q_push),
        .o_q_cmd     (push_cmd),
        .o_bb_wr     (bb_wr),
        .i_rel       (bank_rel)
    );

    rfde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    rfde_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_q_pop   (q_pop),
        .i_bb_wr   (bb_wr),
        .o_rel     (bank_rel),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
